// ===== design/lsbx_pkg.sv =====
// Types, constants and the base64 lookup shared by the LSB extractor.
// No dependencies; compile before every other file of the block.
package lsbx_pkg;

    // Processing phase of the extractor
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_LEN,
        PH_PAY,
        PH_DONE
    } lsbx_phase_t;

    // Result of a base64 alphabet lookup
    typedef struct packed {
        logic       ok;
        logic [5:0] idx;
    } lsbx_sextet_t;

    localparam int unsigned OFFSET_W       = 31;
    localparam int unsigned OFFSET_RESET   = 54;
    localparam int unsigned LBC_W          = 6;
    localparam int unsigned CHAR_W         = 8;
    localparam int unsigned CBC_W          = 3;
    localparam int unsigned ACC_W          = 14;
    localparam int unsigned ABC_W          = 4;
    localparam int unsigned SEXTET_W       = 6;
    localparam int unsigned COUNT_SIGN_BIT = 31;

    // Map a character onto its base64 index (A-Z a-z 0-9 + /); flag others
    function automatic lsbx_sextet_t sextet_of(input logic [7:0] c);
        lsbx_sextet_t r;
        r = '0;
        case (c) inside
            [8'h41:8'h5A]: begin r.ok = 1'b1; r.idx = 6'(c - 8'h41);         end
            [8'h61:8'h7A]: begin r.ok = 1'b1; r.idx = 6'(c - 8'h61 + 8'd26); end
            [8'h30:8'h39]: begin r.ok = 1'b1; r.idx = 6'(c - 8'h30 + 8'd52); end
            8'h2B:         begin r.ok = 1'b1; r.idx = 6'd62;                 end
            8'h2F:         begin r.ok = 1'b1; r.idx = 6'd63;                 end
            default:       r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/lsbx_if.sv =====
// Valid/ready channels of the LSB extractor: carrier bytes in, message bytes out.
// No dependencies.
interface lsbx_carrier_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       new_file;

    modport source (output valid, output file_byte, output new_file, input ready);
    modport sink   (input valid, input file_byte, input new_file, output ready);
endinterface

interface lsbx_message_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       message_end;

    modport source (output valid, output out_byte, output has_byte, output message_end,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input message_end,
                     output ready);
endinterface

// ===== design/lsb_stego_base64_extractor_core.sv =====
// LSB steganography extractor with base64 decode, one carrier byte per item.
// An item passes through the input register and then the result register before its result leaves.
// Throughput: one item per cycle while the result register is free or draining; set by
// the single state update between the input register and the result register.
// Reset: asynchronous, active low; clears all progress and sets pixel_offset to 54.
// Depends on lsbx_pkg and lsbx_if.
module lsb_stego_base64_extractor_core #(
    parameter int unsigned LENGTH_HEADER_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lsbx_pkg::OFFSET_W-1:0]  cfg_wdata,
    lsbx_carrier_if.sink                   carrier,
    lsbx_message_if.source                 message
);
    import lsbx_pkg::*;

    localparam int unsigned CNT_W      = LENGTH_HEADER_BITS;
    localparam int unsigned PAY_W      = LENGTH_HEADER_BITS + 3;
    localparam bit          SIGN_CHECK = (LENGTH_HEADER_BITS - 1 == COUNT_SIGN_BIT);

    // Configuration
    logic [OFFSET_W-1:0] pixel_offset_reg;

    // Input register
    logic s1_valid_reg;
    logic s1_bit_reg;
    logic s1_new_reg;

    // Extraction state
    lsbx_phase_t         phase_reg,   phase_next;
    logic [OFFSET_W-1:0] skip_reg,    skip_next;
    logic [LBC_W-1:0]    lbc_reg,     lbc_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [PAY_W-1:0]    pay_reg,     pay_next;
    logic [CHAR_W-1:0]   shift_reg,   shift_next;
    logic [CBC_W-1:0]    cbc_reg,     cbc_next;
    logic [ACC_W-1:0]    acc_reg,     acc_next;
    logic [ABC_W-1:0]    abc_reg,     abc_next;

    // Output register
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_has_reg;
    logic              out_end_reg;

    // Working signals
    logic              out_room;
    logic              s1_fire;
    lsbx_phase_t       phase_cur;
    logic [OFFSET_W-1:0] skip_cur;
    logic [LBC_W-1:0]  lbc_cur;
    logic [CNT_W-1:0]  count_cur;
    logic              take_len;
    logic              empty_msg;
    lsbx_sextet_t      sx;
    logic [ACC_W-1:0]  acc_wide;
    logic [ABC_W-1:0]  abc_sum;
    logic              res_valid;
    logic [7:0]        res_byte;
    logic              res_has;
    logic              res_end;

    // Handshake: the input stage moves on whenever the result slot is free or draining
    assign out_room      = !out_valid_reg || message.ready;
    assign s1_fire       = s1_valid_reg && out_room;
    assign carrier.ready = !s1_valid_reg || out_room;

    assign message.valid       = out_valid_reg;
    assign message.out_byte    = out_byte_reg;
    assign message.has_byte    = out_has_reg;
    assign message.message_end = out_end_reg;

    // Hold the configured pixel offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_offset_reg <= OFFSET_W'(OFFSET_RESET);
        end
        else if (cfg_we)
        begin
            pixel_offset_reg <= cfg_wdata;
        end
    end

    // Capture the incoming item; only bit 0 of the byte matters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (carrier.ready)
        begin
            s1_valid_reg <= carrier.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (carrier.ready)
        begin
            s1_bit_reg <= carrier.file_byte[0];
            s1_new_reg <= carrier.new_file;
        end
    end

    // Work out the next state and the result of the held item
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        lbc_next   = lbc_reg;
        count_next = count_reg;
        pay_next   = pay_reg;
        shift_next = shift_reg;
        cbc_next   = cbc_reg;
        acc_next   = acc_reg;
        abc_next   = abc_reg;
        res_valid  = 1'b0;
        res_byte   = '0;
        res_has    = 1'b0;
        res_end    = 1'b0;
        empty_msg  = 1'b0;
        sx         = '0;
        acc_wide   = '0;
        abc_sum    = '0;

        // A new file clears all progress before the byte is handled
        phase_cur = s1_new_reg ? PH_SKIP : phase_reg;
        skip_cur  = s1_new_reg ? '0 : skip_reg;
        lbc_cur   = s1_new_reg ? '0 : lbc_reg;
        count_cur = s1_new_reg ? '0 : count_reg;
        take_len  = (phase_cur == PH_LEN) ||
                    ((phase_cur == PH_SKIP) && !(skip_cur < pixel_offset_reg));

        if (s1_fire)
        begin
            if (s1_new_reg)
            begin
                phase_next = PH_SKIP;
                skip_next  = '0;
                lbc_next   = '0;
                count_next = '0;
                pay_next   = '0;
                shift_next = '0;
                cbc_next   = '0;
                acc_next   = '0;
                abc_next   = '0;
            end

            if ((phase_cur == PH_SKIP) && !take_len)
            begin
                // Skip bytes ahead of the pixel data
                skip_next = OFFSET_W'(skip_cur + 1'b1);
            end
            else if (take_len)
            begin
                // Gather the length header, first bit most significant
                phase_next = PH_LEN;
                count_next = {count_cur[CNT_W-2:0], s1_bit_reg};
                lbc_next   = LBC_W'(lbc_cur + 1'b1);
                if (lbc_next == LBC_W'(LENGTH_HEADER_BITS))
                begin
                    empty_msg = (count_next == '0) || (SIGN_CHECK && count_next[CNT_W-1]);
                    if (empty_msg)
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res_end    = 1'b1;
                    end
                    else
                    begin
                        pay_next   = {count_next, 3'b000};
                        phase_next = PH_PAY;
                    end
                end
            end
            else if (phase_cur == PH_PAY)
            begin
                // Shift in a carrier bit and decode each finished character
                shift_next = {shift_reg[CHAR_W-2:0], s1_bit_reg};
                cbc_next   = CBC_W'(cbc_reg + 1'b1);
                pay_next   = PAY_W'(pay_reg - 1'b1);
                sx         = sextet_of(shift_next);
                if ((cbc_next == '0) && sx.ok)
                begin
                    acc_wide = {acc_reg[ACC_W-SEXTET_W-1:0], sx.idx};
                    abc_sum  = ABC_W'(abc_reg + ABC_W'(SEXTET_W));
                    acc_next = acc_wide;
                    abc_next = abc_sum;
                    if (abc_sum >= ABC_W'(CHAR_W))
                    begin
                        abc_next  = ABC_W'(abc_sum - ABC_W'(CHAR_W));
                        res_byte  = 8'(acc_wide >> abc_next);
                        acc_next  = acc_wide & ACC_W'((ACC_W'(1) << abc_next) - 1'b1);
                        res_has   = 1'b1;
                        res_valid = 1'b1;
                    end
                end
                if (pay_next == '0)
                begin
                    phase_next = PH_DONE;
                    res_end    = 1'b1;
                    res_valid  = 1'b1;
                end
            end
        end
    end

    // Advance the extraction state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            skip_reg  <= '0;
            lbc_reg   <= '0;
            count_reg <= '0;
            pay_reg   <= '0;
            shift_reg <= '0;
            cbc_reg   <= '0;
            acc_reg   <= '0;
            abc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            lbc_reg   <= lbc_next;
            count_reg <= count_next;
            pay_reg   <= pay_next;
            shift_reg <= shift_next;
            cbc_reg   <= cbc_next;
            acc_reg   <= acc_next;
            abc_reg   <= abc_next;
        end
    end

    // Load the result register, or drop its item once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_room)
        begin
            out_valid_reg <= s1_fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_room)
        begin
            out_byte_reg <= res_byte;
            out_has_reg  <= res_has;
            out_end_reg  <= res_end;
        end
    end

    // Checks on the extraction state
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res_end |=> phase_reg == PH_DONE)
        else $error("end of message did not reach the done phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        !abc_reg[0] && (abc_reg < ABC_W'(CHAR_W)))
        else $error("base64 bit count left its even range below eight");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEN |-> lbc_reg < LBC_W'(LENGTH_HEADER_BITS))
        else $error("header bit count overran the header length");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAY |-> pay_reg != '0)
        else $error("payload phase with no carrier bytes left");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res_valid |=> out_valid_reg)
        else $error("result of an item was lost");

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for lsb_stego_base64_extractor_core: random and directed carrier files,
// with a built-in decoder model checked against every message item.
// Depends on lsbx_pkg, lsbx_if and the core module.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsbx_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned PHASE_ITEMS   = 400;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] file_byte;
        logic       new_file;
    } carrier_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       message_end;
    } message_item_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [OFFSET_W-1:0] cfg_wdata;

    lsbx_carrier_if carrier_ch();
    lsbx_message_if message_ch();

    lsb_stego_base64_extractor_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .carrier   (carrier_ch),
        .message   (message_ch)
    );

    // Stimulus and expectation stores
    carrier_item_t carrier_pending[$];
    message_item_t message_due[$];
    carrier_item_t drive_item;
    message_item_t got_item;
    message_item_t want_item;

    // Decoder model state
    logic [OFFSET_W-1:0] offset_model;
    lsbx_phase_t         phase_m;
    logic [OFFSET_W-1:0] skipped_m;
    logic [LBC_W-1:0]    hdr_bits_m;
    logic [31:0]         hdr_count_m;
    logic [34:0]         carrier_left_m;
    logic [CHAR_W-1:0]   char_sr_m;
    logic [CBC_W-1:0]    char_bits_m;
    logic [ACC_W-1:0]    acc_m;
    logic [ABC_W-1:0]    acc_bits_m;

    // Flow control and bookkeeping
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned hold_left    = 0;
    logic        hold_off_req = 1'b0;
    int unsigned cycle_count  = 0;
    int unsigned fail_count   = 0;
    int unsigned items_queued = 0;
    int unsigned items_taken  = 0;
    int unsigned bytes_seen   = 0;
    int unsigned ends_seen    = 0;
    int unsigned offsets_set  = 0;

    // Clock: 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stop a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped: cycle limit reached with %0d results outstanding",
                     message_due.size());
            $display("tb failed");
            $finish;
        end
    end

    // Base64 index of a character; return 0 for anything outside the alphabet
    function automatic bit b64_value(input logic [7:0] c, output logic [SEXTET_W-1:0] v);
        v = '0;
        b64_value = 1'b1;
        if (c >= "A" && c <= "Z")
            v = 6'(c - "A");
        else if (c >= "a" && c <= "z")
            v = 6'(c - "a" + 26);
        else if (c >= "0" && c <= "9")
            v = 6'(c - "0" + 52);
        else if (c == "+")
            v = 6'd62;
        else if (c == "/")
            v = 6'd63;
        else
            b64_value = 1'b0;
    endfunction

    function automatic void clear_decoder();
        phase_m        = PH_SKIP;
        skipped_m      = '0;
        hdr_bits_m     = '0;
        hdr_count_m    = '0;
        carrier_left_m = '0;
        char_sr_m      = '0;
        char_bits_m    = '0;
        acc_m          = '0;
        acc_bits_m     = '0;
    endfunction

    // Advance the decoder by one carrier byte and queue the result it gives, if any
    function automatic void decode_carrier(input logic [7:0] fb, input logic nf);
        logic                bit_in;
        logic [SEXTET_W-1:0] idx;
        logic                has;
        logic                last;
        logic [7:0]          value;
        bit_in = fb[0];
        has    = 1'b0;
        last   = 1'b0;
        value  = '0;
        if (nf)
            clear_decoder();
        if (phase_m == PH_SKIP)
        begin
            if (skipped_m < offset_model)
            begin
                skipped_m = skipped_m + 1'b1;
                return;
            end
            phase_m = PH_LEN;
        end
        if (phase_m == PH_LEN)
        begin
            hdr_count_m = {hdr_count_m[30:0], bit_in};
            hdr_bits_m  = hdr_bits_m + 1'b1;
            if (hdr_bits_m < 6'd32)
                return;
            // Sign bit set or zero count: empty message
            if (hdr_count_m[COUNT_SIGN_BIT] || hdr_count_m == '0)
            begin
                phase_m = PH_DONE;
                message_due.push_back('{out_byte: 8'h00, has_byte: 1'b0, message_end: 1'b1});
                return;
            end
            carrier_left_m = {hdr_count_m, 3'b000};
            phase_m        = PH_PAY;
            return;
        end
        if (phase_m == PH_DONE)
            return;
        // Payload: gather a character, feed valid sextets into the byte buffer
        char_sr_m      = {char_sr_m[6:0], bit_in};
        char_bits_m    = char_bits_m + 1'b1;
        carrier_left_m = carrier_left_m - 1'b1;
        if (char_bits_m == '0 && b64_value(char_sr_m, idx))
        begin
            acc_m      = {acc_m[7:0], idx};
            acc_bits_m = acc_bits_m + 4'd6;
            if (acc_bits_m >= 4'd8)
            begin
                acc_bits_m = acc_bits_m - 4'd8;
                value      = 8'(acc_m >> acc_bits_m);
                acc_m      = acc_m & ((14'd1 << acc_bits_m) - 14'd1);
                has        = 1'b1;
            end
        end
        if (carrier_left_m == '0)
        begin
            last    = 1'b1;
            phase_m = PH_DONE;
        end
        if (has || last)
            message_due.push_back('{out_byte: value, has_byte: has, message_end: last});
    endfunction

    task automatic report_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: hold the item until taken, then offer the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_ch.valid     <= 1'b0;
            carrier_ch.file_byte <= '0;
            carrier_ch.new_file  <= 1'b0;
        end
        else if (!carrier_ch.valid || carrier_ch.ready)
        begin
            if (carrier_pending.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                drive_item = carrier_pending.pop_front();
                carrier_ch.valid     <= 1'b1;
                carrier_ch.file_byte <= drive_item.file_byte;
                carrier_ch.new_file  <= drive_item.new_file;
            end
            else
                carrier_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_ch.ready <= 1'b0;
            hold_left        <= 0;
        end
        else if (hold_off_req)
        begin
            hold_off_req     <= 1'b0;
            hold_left        <= HOLD_CYCLES;
            message_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left        <= hold_left - 1;
            message_ch.ready <= 1'b0;
        end
        else
            message_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Monitor: check each message item, then predict from each carrier item taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (message_ch.valid && message_ch.ready)
            begin
                got_item = '{out_byte: message_ch.out_byte, has_byte: message_ch.has_byte,
                             message_end: message_ch.message_end};
                if (message_due.size() == 0)
                begin
                    $error("unexpected item: out_byte %0h has_byte %0b message_end %0b",
                           got_item.out_byte, got_item.has_byte, got_item.message_end);
                    fail_count++;
                end
                else
                begin
                    want_item = message_due.pop_front();
                    report_field("out_byte", want_item.out_byte, got_item.out_byte);
                    report_field("has_byte", want_item.has_byte, got_item.has_byte);
                    report_field("message_end", want_item.message_end, got_item.message_end);
                    if (want_item.has_byte)
                        bytes_seen++;
                    if (want_item.message_end)
                        ends_seen++;
                end
            end
            if (carrier_ch.valid && carrier_ch.ready)
            begin
                items_taken++;
                decode_carrier(carrier_ch.file_byte, carrier_ch.new_file);
            end
        end
    end

    task automatic push_byte(input logic [7:0] fb, input logic nf);
        carrier_pending.push_back('{file_byte: fb, new_file: nf});
        items_queued++;
    endtask

    // Skip bytes, then the 32-bit character count, first bit most significant
    task automatic start_file(input int unsigned skip_n, input logic [31:0] count);
        for (int i = 0; i < skip_n; i++)
            push_byte(8'($urandom), i == 0);
        for (int i = 31; i >= 0; i--)
            push_byte({7'($urandom), count[i]}, skip_n == 0 && i == 31);
    endtask

    task automatic push_char(input logic [7:0] c);
        for (int i = 7; i >= 0; i--)
            push_byte({7'($urandom), c[i]}, 1'b0);
    endtask

    function automatic logic [7:0] random_char();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 82)
            return B64_ALPHABET[$urandom_range(63)];
        else if (pick < 90)
            return "=";
        return 8'($urandom);
    endfunction

    // Wait until nothing is in flight, then let trailing items settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (carrier_pending.size() != 0 || carrier_ch.valid || message_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        offset_model  = value;
        offsets_set++;
    endtask

    // One file: mostly well formed, some misaligned, empty, cut short or noisy
    task automatic queue_random_file();
        int unsigned kind;
        int unsigned n_chars;
        int unsigned skip_n;
        logic [31:0] count;
        kind    = $urandom_range(99);
        n_chars = $urandom_range(1, 14);
        skip_n  = offset_model;
        count   = n_chars;
        if (kind < 5)
            skip_n = $urandom_range(0, offset_model + 4);
        else if (kind < 9)
            count = $urandom();
        else if (kind < 13)
            count = $urandom_range(1) ? 32'h0 : {1'b1, 31'($urandom)};
        else if (kind < 19)
            n_chars = $urandom_range(0, n_chars - 1);
        start_file(skip_n, count);
        repeat (n_chars) push_char(random_char());
        if (kind >= 94)
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(7) == 0);
        else
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
    endtask

    task automatic random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                input bit with_hold_off);
        int unsigned target;
        int unsigned files;
        target       = items_queued + PHASE_ITEMS;
        files        = 0;
        wait_drained();
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        if (with_hold_off)
        begin
            // Long message with the receiver held off, so the input backs up
            write_offset('0);
            start_file(0, 40);
            repeat (40) push_char(B64_ALPHABET[$urandom_range(63)]);
            hold_off_req <= 1'b1;
        end
        while (items_queued < target)
        begin
            if (files % 5 == 0)
            begin
                case ($urandom_range(5))
                    0:       write_offset('0);
                    1:       write_offset(31'd1);
                    2:       write_offset(31'(OFFSET_RESET));
                    default: write_offset(31'($urandom_range(2, 20)));
                endcase
            end
            queue_random_file();
            files++;
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        carrier_ch.valid     = 1'b0;
        carrier_ch.file_byte = '0;
        carrier_ch.new_file  = 1'b0;
        message_ch.ready     = 1'b0;
        offset_model         = 31'(OFFSET_RESET);
        clear_decoder();
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Offset left at its reset value: "TWFu" decodes to "Man"
        src_idle_pct = 24;
        snk_idle_pct = 58;
        start_file(OFFSET_RESET, 4);
        push_char("T");
        push_char("W");
        push_char("F");
        push_char("u");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);

        // Largest offset: everything is skipped, new_file included
        write_offset(OFFSET_MAX);
        for (int i = 0; i < 12; i++)
            push_byte(8'($urandom), i % 4 == 0);

        // Empty messages: zero count, sign bit alone, all ones; trailing bytes ignored
        write_offset('0);
        start_file(0, 32'h0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        start_file(0, 32'h8000_0000);
        start_file(0, 32'hFFFF_FFFF);

        // Padding ignored; end without a byte
        start_file(0, 3);
        push_char("Q");
        push_char("Q");
        push_char("=");
        // Top of the alphabet
        start_file(0, 4);
        push_char("/");
        push_char("+");
        push_char("9");
        push_char("a");
        // Noise character, then leftover bits dropped
        start_file(0, 2);
        push_char("*");
        push_char("z");
        // File cut short mid payload, then mid header
        start_file(0, 5);
        push_char("A");
        push_char("B");
        push_byte(8'hFF, 1'b1);
        for (int i = 0; i < 10; i++)
            push_byte(8'($urandom), 1'b0);
        start_file(0, 1);
        push_char("?");

        // Offset of one
        write_offset(31'd1);
        start_file(1, 1);
        push_char("Z");

        // Random files under three idling patterns
        random_phase(24, 58, 1'b0);
        random_phase(58, 24, 1'b0);
        random_phase(0, 0, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d carrier items, %0d decoded bytes and %0d message ends",
                 items_taken, bytes_seen, ends_seen);
        $display("over %0d offset settings, with a long receiver hold-off.", offsets_set);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
